FILE: rtl/mono_bitmap_blit_page_refresh_defines.svh
// Assertion shorthands shared by the blit block.
`ifndef MONO_BITMAP_BLIT_PAGE_REFRESH_DEFINES_SVH
`define MONO_BITMAP_BLIT_PAGE_REFRESH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MBB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MBB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mbb_pkg.sv
package mbb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 32;

  localparam logic [7:0] BMP_MAX_WIDTH = 8'd128;

  // Configuration reset values
  localparam logic [7:0] BMP_WIDTH_RST  = 8'd128;
  localparam logic [5:0] BMP_HEIGHT_RST = 6'd32;
  localparam logic [7:0] X_ORIGIN_RST   = 8'd0;
  localparam logic [5:0] Y_ORIGIN_RST   = 6'd0;
  localparam logic       DRAW_COLOR_RST = 1'b1;

  // Display command bytes
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_FLUSH = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    CFG_BMP_WIDTH  = 3'd0,
    CFG_BMP_HEIGHT = 3'd1,
    CFG_X_ORIGIN   = 3'd2,
    CFG_Y_ORIGIN   = 3'd3,
    CFG_DRAW_COLOR = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMDSEL_PAGE = 2'd0,
    CMDSEL_LO   = 2'd1,
    CMDSEL_HI   = 2'd2
  } cmd_sel_t;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_CLEAR     = 7'b0000010,
    ST_DRAW      = 7'b0000100,
    ST_DRAW_END  = 7'b0001000,
    ST_CMD       = 7'b0010000,
    ST_FETCH     = 7'b0100000,
    ST_FETCH_END = 7'b1000000
  } state_t;

  // Pixel update request from the address unit
  typedef struct packed {
    logic       en;
    logic [7:0] mask;
  } pix_req_t;

  function automatic logic [7:0] clip_width(input logic [7:0] w);
    clip_width = (w > BMP_MAX_WIDTH) ? BMP_MAX_WIDTH : w;
  endfunction

endpackage

FILE: rtl/mbb_ram.sv
module mbb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/mbb_pix_addr.sv
module mbb_pix_addr import mbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int ADDR_W        = 9
) (
  input  logic [7:0]        bmp_width,
  input  logic [7:0]        x_origin,
  input  logic [5:0]        y_origin,
  input  logic [5:0]        row_count,
  input  logic [3:0]        byte_col,
  input  logic [2:0]        bit_idx,
  input  logic [7:0]        pixel_byte,
  output pix_req_t          req,
  output logic [ADDR_W-1:0] addr
);

  localparam logic signed [9:0] SW_S = 10'(SCREEN_WIDTH);
  localparam logic signed [7:0] SH_S = 8'(SCREEN_HEIGHT);

  logic [7:0]        w_clip;
  logic [6:0]        col_i;
  logic              in_bmp;
  logic              lit;
  logic signed [9:0] bx;
  logic signed [7:0] by;
  logic              on_screen;

  always_comb begin
    w_clip    = clip_width(bmp_width);
    col_i     = {byte_col, bit_idx};
    in_bmp    = {1'b0, col_i} < w_clip;
    lit       = pixel_byte[3'd7 - bit_idx];
    bx        = $signed({{2{x_origin[7]}}, x_origin}) + $signed({3'b000, col_i});
    by        = $signed({{2{y_origin[5]}}, y_origin}) + $signed({2'b00, row_count});
    on_screen = !bx[9] && (bx < SW_S) && !by[7] && (by < SH_S);
    req.en    = in_bmp && lit && on_screen;
    req.mask  = 8'(1) << by[2:0];
    addr      = ADDR_W'(by[5:3]) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(bx[8:0]);
  end

endmodule

FILE: rtl/mono_bitmap_blit_page_refresh.sv
// Channel   Ports                                         Handshake
// -------   --------------------------------------------  -----------------------------
// request   in_func, in_pixel_byte, in_page_index         start & !busy
// result    out_kind, out_cmd_byte, out_data_word, out_last  out_valid, one cycle each
// config    cfg_index, cfg_data                           cfg_we, taken every edge
//
// A bitmap byte holds busy while it steps through its bit slots: a frame read for
// each lit, on-screen pixel, its write-back in the next cycle on the single-read,
// single-write frame RAM. A flush holds busy while it sends three commands, then
// reads one frame byte per cycle, a chunk every eighth. Start and reset sweep the
// frame RAM one byte a cycle, SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes (512 by
// default), with busy high.
// Ignored requests do not raise busy. Results cannot be stalled.
`include "mono_bitmap_blit_page_refresh_defines.svh"

module mono_bitmap_blit_page_refresh import mbb_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_pixel_byte,
  input  logic [1:0]  in_page_index,
  output logic        out_valid,
  output logic        out_kind,
  output logic [7:0]  out_cmd_byte,
  output logic [63:0] out_data_word,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_SIZE  = SCREEN_WIDTH * PAGE_COUNT;
  localparam int CHUNK_COUNT = (SCREEN_WIDTH + 7) / 8;
  localparam int COLS_PAD    = CHUNK_COUNT * 8;
  localparam int ADDR_W      = $clog2(STORE_SIZE);
  localparam int COL_W       = $clog2(COLS_PAD);

  // configuration
  logic [7:0] bmp_width_r;
  logic [5:0] bmp_height_r;
  logic [7:0] x_origin_r;
  logic [5:0] y_origin_r;
  logic       draw_color_r;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [5:0]        row_r, row_nxt;
  logic [3:0]        bcol_r, bcol_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [7:0]        pbyte_r, pbyte_nxt;
  logic [1:0]        page_r, page_nxt;
  logic [1:0]        cmd_cnt_r, cmd_cnt_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;

  logic              wr_v_r, wr_v_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic [7:0]        wr_mask_r, wr_mask_nxt;

  logic              fv_r, fv_nxt;
  logic [2:0]        fsel_r, fsel_nxt;
  logic              fin_r, fin_nxt;
  logic              flast_r, flast_nxt;
  logic [63:0]       word_r, word_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [7:0]        out_cmd_r, out_cmd_nxt;
  logic [63:0]       out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;

  pix_req_t          pix_req;
  logic [ADDR_W-1:0] pix_addr;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [4:0]        stride;
  logic              accept;
  logic              page_ok;
  logic [ADDR_W-1:0] fetch_addr;
  logic [7:0]        fetch_byte;
  logic [63:0]       word_shift;

  mbb_pix_addr #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_pix (
    .bmp_width (bmp_width_r),
    .x_origin  (x_origin_r),
    .y_origin  (y_origin_r),
    .row_count (row_r),
    .byte_col  (bcol_r),
    .bit_idx   (bit_r),
    .pixel_byte(pbyte_r),
    .req       (pix_req),
    .addr      (pix_addr)
  );

  mbb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_SIZE)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stride     = 5'(({1'b0, clip_width(bmp_width_r)} + 9'd7) >> 3);
    accept     = start && (state_r == ST_IDLE);
    page_ok    = {2'b00, in_page_index} < 4'(PAGE_COUNT);
    fetch_addr = ADDR_W'(page_r) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_r);
    fetch_byte = fin_r ? ram_rdata : 8'h00;
    word_shift = {fetch_byte, word_r[63:8]};

    ram_we     = (state_r == ST_CLEAR) || wr_v_r;
    ram_waddr  = (state_r == ST_CLEAR) ? clr_addr_r : wr_addr_r;
    if (state_r == ST_CLEAR) begin
      ram_wdata = 8'h00;
    end else if (draw_color_r) begin
      ram_wdata = ram_rdata | wr_mask_r;
    end else begin
      ram_wdata = ram_rdata & ~wr_mask_r;
    end
    ram_re    = ((state_r == ST_DRAW) && pix_req.en) || (state_r == ST_FETCH);
    ram_raddr = (state_r == ST_DRAW) ? pix_addr : fetch_addr;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    row_nxt       = row_r;
    bcol_nxt      = bcol_r;
    bit_nxt       = bit_r;
    pbyte_nxt     = pbyte_r;
    page_nxt      = page_r;
    cmd_cnt_nxt   = cmd_cnt_r;
    col_nxt       = col_r;
    wr_v_nxt      = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    wr_mask_nxt   = wr_mask_r;
    fv_nxt        = 1'b0;
    fsel_nxt      = fsel_r;
    fin_nxt       = fin_r;
    flast_nxt     = flast_r;
    word_nxt      = word_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_cmd_nxt   = out_cmd_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    // collect fetched bytes, emit a chunk on every eighth
    if (fv_r) begin
      word_nxt = word_shift;
      if (fsel_r == 3'd7) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_DATA;
        out_cmd_nxt   = 8'h00;
        out_data_nxt  = word_shift;
        out_last_nxt  = flast_r;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (func_t'(in_func))
            FUNC_START: begin
              row_nxt      = '0;
              bcol_nxt     = '0;
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            FUNC_PIXEL: begin
              if ((stride != 5'd0) && (row_r < bmp_height_r)) begin
                bit_nxt   = '0;
                pbyte_nxt = in_pixel_byte;
                state_nxt = ST_DRAW;
              end
            end
            FUNC_FLUSH: begin
              if (page_ok) begin
                page_nxt    = in_page_index;
                cmd_cnt_nxt = '0;
                state_nxt   = ST_CMD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DRAW: begin
        // read this bit's byte now, write it back next cycle
        wr_v_nxt    = pix_req.en;
        wr_addr_nxt = pix_addr;
        wr_mask_nxt = pix_req.mask;
        bit_nxt     = bit_r + 1'b1;
        if (bit_r == 3'd7) begin
          state_nxt = ST_DRAW_END;
        end
      end
      ST_DRAW_END: begin
        if ({1'b0, bcol_r} + 5'd1 >= stride) begin
          bcol_nxt = '0;
          row_nxt  = row_r + 1'b1;
        end else begin
          bcol_nxt = bcol_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_CMD: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_CMD;
        out_data_nxt  = '0;
        out_last_nxt  = 1'b0;
        unique case (cmd_sel_t'(cmd_cnt_r))
          CMDSEL_PAGE: out_cmd_nxt = CMD_PAGE_BASE + {6'b000000, page_r};
          CMDSEL_LO:   out_cmd_nxt = CMD_COL_LO;
          CMDSEL_HI:   out_cmd_nxt = CMD_COL_HI;
          default:     out_cmd_nxt = CMD_COL_LO;
        endcase
        cmd_cnt_nxt = cmd_cnt_r + 1'b1;
        if (cmd_sel_t'(cmd_cnt_r) == CMDSEL_HI) begin
          col_nxt   = '0;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        fv_nxt    = 1'b1;
        fsel_nxt  = col_r[2:0];
        fin_nxt   = {1'b0, col_r} < (COL_W + 1)'(SCREEN_WIDTH);
        flast_nxt = (col_r == COL_W'(COLS_PAD - 1));
        col_nxt   = col_r + 1'b1;
        if (col_r == COL_W'(COLS_PAD - 1)) begin
          state_nxt = ST_FETCH_END;
        end
      end
      ST_FETCH_END: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      row_r        <= '0;
      bcol_r       <= '0;
      wr_v_r       <= 1'b0;
      fv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      bmp_width_r  <= BMP_WIDTH_RST;
      bmp_height_r <= BMP_HEIGHT_RST;
      x_origin_r   <= X_ORIGIN_RST;
      y_origin_r   <= Y_ORIGIN_RST;
      draw_color_r <= DRAW_COLOR_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      row_r       <= row_nxt;
      bcol_r      <= bcol_nxt;
      wr_v_r      <= wr_v_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_BMP_WIDTH:  bmp_width_r  <= cfg_data;
          CFG_BMP_HEIGHT: bmp_height_r <= cfg_data[5:0];
          CFG_X_ORIGIN:   x_origin_r   <= cfg_data;
          CFG_Y_ORIGIN:   y_origin_r   <= cfg_data[5:0];
          CFG_DRAW_COLOR: draw_color_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bit_r      <= bit_nxt;
    pbyte_r    <= pbyte_nxt;
    page_r     <= page_nxt;
    cmd_cnt_r  <= cmd_cnt_nxt;
    col_r      <= col_nxt;
    wr_addr_r  <= wr_addr_nxt;
    wr_mask_r  <= wr_mask_nxt;
    fsel_r     <= fsel_nxt;
    fin_r      <= fin_nxt;
    flast_r    <= flast_nxt;
    word_r     <= word_nxt;
    out_kind_r <= out_kind_nxt;
    out_cmd_r  <= out_cmd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_cmd_byte  = out_cmd_r;
  assign out_data_word = out_data_r;
  assign out_last      = out_last_r;

  `MBB_ASSERT_IMP(a_no_result_in_draw, (state_r == ST_DRAW) || (state_r == ST_CLEAR), !out_valid_r, "result during draw or clear")
  `MBB_ASSERT_IMP(a_rmw_no_overlap, ram_we && ram_re, ram_waddr != ram_raddr, "read and write of one frame byte")
  `MBB_ASSERT_IMP(a_last_is_data, out_valid_r && out_last_r, out_kind_r == KIND_DATA, "last on a command")
  `MBB_ASSERT_NXT(a_flush_starts, accept && (in_func == FUNC_FLUSH) && page_ok, state_r == ST_CMD, "flush request not started")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import mbb_pkg::*;

  localparam int SCREEN_W  = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H  = SCREEN_HEIGHT_DEF;
  localparam int PAGES     = (SCREEN_H + 7) / 8;
  localparam int CHUNKS    = (SCREEN_W + 7) / 8;
  localparam int STORE     = SCREEN_W * PAGES;
  localparam int ITEM_GOAL = 300;
  localparam int MAX_BYTES = 48;

  // func code the block has no operation for
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // register index past the last register
  localparam logic [2:0] CFG_NONE = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [7:0]  cmd;
    logic [63:0] data;
    logic        last;
  } transfer_t;

  class frame_predictor;
    logic [7:0]        pixels [STORE];
    logic [5:0]        row_cnt;
    logic [3:0]        col_cnt;
    logic [7:0]        width_r;
    logic [5:0]        height_r;
    logic signed [7:0] x_org;
    logic signed [5:0] y_org;
    logic              color;
    transfer_t         refresh_due [$];
    int                errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      row_cnt  = '0;
      col_cnt  = '0;
      width_r  = BMP_WIDTH_RST;
      height_r = BMP_HEIGHT_RST;
      x_org    = X_ORIGIN_RST;
      y_org    = Y_ORIGIN_RST;
      color    = DRAW_COLOR_RST;
      errors   = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [7:0] val);
      case (idx)
        CFG_BMP_WIDTH:  width_r  = val;
        CFG_BMP_HEIGHT: height_r = val[5:0];
        CFG_X_ORIGIN:   x_org    = val;
        CFG_Y_ORIGIN:   y_org    = val[5:0];
        CFG_DRAW_COLOR: color    = val[0];
        default: ;
      endcase
    endfunction

    function int stride();
      int w;
      w = (width_r > BMP_MAX_WIDTH) ? int'(BMP_MAX_WIDTH) : int'(width_r);
      return (w + 7) / 8;
    endfunction

    // bytes still taken by the image; cleared means counters at zero
    function int bytes_left(bit cleared);
      int s, row, col;
      s   = stride();
      row = cleared ? 0 : int'(row_cnt);
      col = cleared ? 0 : int'(col_cnt);
      if (s == 0 || row >= int'(height_r)) return 0;
      return (int'(height_r) - row - 1) * s + ((col >= s) ? 1 : s - col);
    endfunction

    function void blit_byte(logic [7:0] pix);
      int w, s, col, bx, by, idx;
      w = (width_r > BMP_MAX_WIDTH) ? int'(BMP_MAX_WIDTH) : int'(width_r);
      s = stride();
      if (s == 0 || row_cnt >= height_r) return;
      for (int b = 0; b < 8; b++) begin
        col = int'(col_cnt) * 8 + b;
        bx  = int'(x_org) + col;
        by  = int'(y_org) + int'(row_cnt);
        if (col < w && pix[7-b] && bx >= 0 && bx < SCREEN_W && by >= 0 && by < SCREEN_H) begin
          idx = bx + (by / 8) * SCREEN_W;
          pixels[idx][by % 8] = color;
        end
      end
      // row ends after this byte even if the stride shrank below the column
      if (int'(col_cnt) + 1 >= s) begin
        col_cnt = '0;
        row_cnt = row_cnt + 1'b1;
      end else begin
        col_cnt = col_cnt + 1'b1;
      end
    endfunction

    function void push_transfer(logic kind, logic [7:0] cmd, logic [63:0] data, logic last);
      transfer_t t;
      t.kind = kind;
      t.cmd  = cmd;
      t.data = data;
      t.last = last;
      refresh_due.push_back(t);
    endfunction

    function void queue_page(logic [1:0] page);
      logic [63:0] word;
      int col;
      if (int'(page) >= PAGES) return;
      push_transfer(KIND_CMD, CMD_PAGE_BASE + 8'(page), '0, 1'b0);
      push_transfer(KIND_CMD, CMD_COL_LO, '0, 1'b0);
      push_transfer(KIND_CMD, CMD_COL_HI, '0, 1'b0);
      for (int c = 0; c < CHUNKS; c++) begin
        word = '0;
        for (int k = 0; k < 8; k++) begin
          col = c * 8 + k;
          if (col < SCREEN_W) word[8*k +: 8] = pixels[int'(page) * SCREEN_W + col];
        end
        push_transfer(KIND_DATA, 8'h00, word, c == CHUNKS - 1);
      end
    endfunction

    function void take_request(logic [1:0] func, logic [7:0] pix, logic [1:0] page);
      case (func)
        FUNC_START: begin
          foreach (pixels[i]) pixels[i] = '0;
          row_cnt = '0;
          col_cnt = '0;
        end
        FUNC_PIXEL: blit_byte(pix);
        FUNC_FLUSH: queue_page(page);
        default: ;
      endcase
    endfunction

    function void flag(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      $display("%0t mismatch %s: expected %h, got %h", $time, field, want, got);
    endfunction

    function void match_transfer(logic kind, logic [7:0] cmd, logic [63:0] data, logic last);
      transfer_t want;
      if (refresh_due.size() == 0) begin
        errors++;
        $display("%0t unexpected transfer: expected none, got kind %b cmd %h data %h last %b",
                 $time, kind, cmd, data, last);
        return;
      end
      want = refresh_due.pop_front();
      if (kind !== want.kind) flag("kind", 64'(want.kind), 64'(kind));
      if (cmd  !== want.cmd)  flag("cmd_byte", 64'(want.cmd), 64'(cmd));
      if (data !== want.data) flag("data_word", want.data, data);
      if (last !== want.last) flag("last", 64'(want.last), 64'(last));
    endfunction

    function int pending();
      return refresh_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n         = 1'b0;
  logic        start         = 1'b0;
  logic        busy;
  logic [1:0]  in_func       = '0;
  logic [7:0]  in_pixel_byte = '0;
  logic [1:0]  in_page_index = '0;
  logic        out_valid;
  logic        out_kind;
  logic [7:0]  out_cmd_byte;
  logic [63:0] out_data_word;
  logic        out_last;
  logic        cfg_we        = 1'b0;
  logic [2:0]  cfg_index     = '0;
  logic [7:0]  cfg_data      = '0;

  frame_predictor sb = new();
  bit steady     = 1'b0;
  int burst_left = 0;

  mono_bitmap_blit_page_refresh dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_pixel_byte (in_pixel_byte),
    .in_page_index (in_page_index),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_cmd_byte  (out_cmd_byte),
    .out_data_word (out_data_word),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.take_request(in_func, in_pixel_byte, in_page_index);
      if (out_valid) sb.match_transfer(out_kind, out_cmd_byte, out_data_word, out_last);
    end
  end

  // hold the request until the block takes it
  task automatic issue(input logic [1:0] func, input logic [7:0] pix, input logic [1:0] page);
    start         <= 1'b1;
    in_func       <= func;
    in_pixel_byte <= pix;
    in_page_index <= page;
    do @(posedge clk); while (busy);
  endtask

  task automatic pace();
    if (!steady) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        start <= 1'b0;
        repeat ((($urandom_range(0, 3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 10)))
          @(posedge clk);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  // drop start, wait for every transfer, then for the block to go idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (16) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int  counted, nbytes, mid, phase, v;
    bit  fresh;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // reset registers: full-screen bitmap
    issue(FUNC_FLUSH, 8'h00, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'h80, 2'd3);    pace();
    issue(FUNC_PIXEL, 8'h01, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'h55, 2'd1);    pace();
    issue(FUNC_UNUSED, 8'hAA, 2'd3);   pace();
    issue(FUNC_FLUSH, 8'hFF, 2'd0);    pace();
    issue(FUNC_FLUSH, 8'h00, 2'd3);    pace();
    issue(FUNC_START, 8'hFF, 2'd3);    pace();
    issue(FUNC_FLUSH, 8'h00, 2'd1);    pace();

    // bottom-right corner, most pixels clipped, then bytes past the image
    settle();
    cfg_write(CFG_BMP_WIDTH, 8'd9);
    cfg_write(CFG_BMP_HEIGHT, 8'd2);
    cfg_write(CFG_X_ORIGIN, 8'h7F);
    cfg_write(CFG_Y_ORIGIN, 8'h1F);
    cfg_write(CFG_DRAW_COLOR, 8'h01);
    issue(FUNC_START, 8'h00, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'h7F, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'h80, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'h12, 2'd0);    pace();
    issue(FUNC_FLUSH, 8'h00, 2'd3);    pace();

    // zero width, register index past the list, width above the clip
    settle();
    cfg_write(CFG_BMP_WIDTH, 8'd0);
    cfg_write(CFG_NONE, 8'hFF);
    issue(FUNC_START, 8'h00, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    settle();
    cfg_write(CFG_BMP_WIDTH, 8'hFF);
    cfg_write(CFG_BMP_HEIGHT, 8'd1);
    cfg_write(CFG_X_ORIGIN, 8'hFC);
    cfg_write(CFG_Y_ORIGIN, 8'h00);
    issue(FUNC_PIXEL, 8'hF0, 2'd0);    pace();
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    issue(FUNC_FLUSH, 8'h00, 2'd0);    pace();

    // most negative origins, erase color
    settle();
    cfg_write(CFG_BMP_HEIGHT, 8'd32);
    cfg_write(CFG_X_ORIGIN, 8'h80);
    cfg_write(CFG_Y_ORIGIN, 8'hE0);
    cfg_write(CFG_DRAW_COLOR, 8'h00);
    issue(FUNC_PIXEL, 8'hFF, 2'd0);    pace();
    issue(FUNC_FLUSH, 8'h00, 2'd2);    pace();

    counted = 0;
    phase   = 0;
    while (counted < ITEM_GOAL) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 128;
          2: v = 255;
          3: v = 1;
          default: v = $urandom_range(1, 40);
        endcase
        cfg_write(CFG_BMP_WIDTH, 8'(v));
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 32;
          2: v = 63;
          3: v = 1;
          default: v = $urandom_range(1, 6);
        endcase
        cfg_write(CFG_BMP_HEIGHT, 8'(v));
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: v = -128;
          1: v = 127;
          2: v = 48;
          3: v = $urandom_range(0, 255);
          default: v = int'($urandom_range(0, 56)) - 16;
        endcase
        cfg_write(CFG_X_ORIGIN, 8'(v));
      end
      if (phase == 0 || $urandom_range(0, 1)) begin
        case ($urandom_range(0, 7))
          0: v = -32;
          1: v = 31;
          2: v = $urandom_range(0, 255);
          default: v = int'($urandom_range(0, 24)) - 4;
        endcase
        cfg_write(CFG_Y_ORIGIN, 8'(v));
      end
      if (phase == 0 || $urandom_range(0, 1))
        cfg_write(CFG_DRAW_COLOR, ($urandom_range(0, 3) != 0) ? 8'h01 : 8'hFE);

      // skipping the start keeps the counters across the register change
      fresh  = ($urandom_range(0, 3) != 0);
      nbytes = sb.bytes_left(fresh);
      if (nbytes > MAX_BYTES) nbytes = MAX_BYTES;
      case ($urandom_range(0, 9))
        0: nbytes = $urandom_range(0, nbytes);
        1: nbytes = nbytes + $urandom_range(1, 4);
        default: ;
      endcase
      mid = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, nbytes)) : -1;

      if (fresh) begin
        issue(FUNC_START, 8'($urandom), 2'($urandom));
        counted++;
        pace();
      end
      for (int k = 0; k < nbytes; k++) begin
        if (k == mid) begin
          issue(FUNC_FLUSH, 8'($urandom), 2'($urandom));
          counted++;
          pace();
        end
        if ($urandom_range(0, 15) == 0) begin
          issue(FUNC_UNUSED, 8'($urandom), 2'($urandom));
          pace();
        end
        issue(FUNC_PIXEL, 8'($urandom), 2'($urandom));
        counted++;
        pace();
      end
      repeat ($urandom_range(1, 2)) begin
        issue(FUNC_FLUSH, 8'($urandom), 2'($urandom));
        counted++;
        pace();
      end
      phase++;
    end

    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS mono_bitmap_blit_page_refresh");
    end else begin
      $display("FAIL mono_bitmap_blit_page_refresh");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL mono_bitmap_blit_page_refresh");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mbb_pkg.sv
rtl/mbb_ram.sv
rtl/mbb_pix_addr.sv
rtl/mono_bitmap_blit_page_refresh.sv
sim/tb.sv
